// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/rtoe_pkg.sv -----
// Types, constants and helpers of the RTO estimator table.
// No dependencies; imported by every module of the block.
package rtoe_pkg;

  localparam int ALU_W = 36;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    REG_RTO_MIN    = 2'd0,
    REG_RTO_MAX    = 2'd1,
    REG_MIN_RTTVAR = 2'd2
  } reg_index_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
  } alu_res_t;

  typedef struct packed {
    logic               mode;
    logic [2:0]         entry_index;
    logic signed [31:0] delay_sample;
  } in_item_t;

  typedef struct packed {
    logic [30:0] smoothed_rtt;
    logic [31:0] rtt_variance;
    logic [31:0] timeout_value;
    logic [31:0] sample_count;
    logic        was_first;
  } out_item_t;

  typedef struct packed {
    logic [30:0] srtt;
    logic [31:0] rttvar;
    logic [31:0] rto;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_DIFF_SWAP,
    ST_VAR3,
    ST_VAR_ADD,
    ST_VAR_FLOOR,
    ST_SRTT7,
    ST_SRTT_ADD,
    ST_RTO,
    ST_FIRST,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_COUNT,
    ST_DONE
  } seq_state_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- design/rto_estimator_table.sv -----
// Retransmission-timeout estimator table: sequencer, entry store, config.
// Depends on rtoe_pkg, rtoe_alu and rtoe_ram.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one request: a sample
//   (mode 0) updates the addressed entry's srtt, rttvar, rto and count, a
//   clear (mode 1) marks the entry unmeasured. Every request yields one
//   result on out_valid/out_stall/out_item with the entry after the step.
//   in_stall is high while a request is in work; one request at a time.
//   A clear or an index past the table goes from the read step straight to
//   the done step; a sample steps through the arithmetic states, clamp and
//   count included, which share the single 36-bit add/subtract unit, used
//   once per arithmetic step.
//   The result register loads on the last step and is visible the cycle
//   after; while out_stall holds it, the last step waits and the result
//   stays put. A new request can be taken while a result waits.
//   Reset clears the measured and written flags of all entries (unwritten
//   entries read as zero), the config registers to their defaults and
//   out_valid; in_stall is low from reset on. Config registers sit at
//   byte addresses 0, 4, 8.
module rto_estimator_table import rtoe_pkg::*; #(
  parameter int ENTRY_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = addr_bits(ENTRY_COUNT);

  // Configuration registers
  logic [31:0] rto_min;
  logic [31:0] rto_max;
  logic [15:0] min_rttvar;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rto_min    <= 32'd1000;
      rto_max    <= 32'd60000;
      min_rttvar <= 16'd1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_RTO_MIN:    rto_min    <= pwdata;
        REG_RTO_MAX:    rto_max    <= pwdata;
        REG_MIN_RTTVAR: min_rttvar <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RTO_MIN:    prdata = rto_min;
      REG_RTO_MAX:    prdata = rto_max;
      REG_MIN_RTTVAR: prdata = {16'b0, min_rttvar};
      default:        prdata = 32'b0;
    endcase
  end

  // Sequencer and datapath registers
  seq_state_t state, state_next;

  logic             mode;
  logic [IDX_W-1:0] addr;
  logic             in_range;
  logic [30:0]      rtt;
  logic [30:0]      srtt;
  logic [31:0]      rttvar;
  logic [30:0]      diff;
  logic [ALU_W-1:0] acc;
  logic [31:0]      nv;
  logic [30:0]      ns;
  logic [ALU_W-1:0] rto;
  logic [31:0]      count;
  logic             first;

  logic [ENTRY_COUNT-1:0] written;
  logic [ENTRY_COUNT-1:0] measured;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  alu_res_t         alu_res;

  logic   advance;
  logic   sample_hit;
  logic   ram_we;
  entry_t ram_rdata;
  entry_t ram_wdata;
  entry_t entry_rd;

  assign advance    = !out_valid || !out_stall;
  assign sample_hit = in_range && (mode == MODE_SAMPLE);
  assign ram_we     = (state == ST_DONE) && advance && sample_hit;
  assign in_stall   = (state != ST_IDLE);
  assign entry_rd   = written[addr] ? ram_rdata : '0;

  assign ram_wdata.srtt   = srtt;
  assign ram_wdata.rttvar = rttvar;
  assign ram_wdata.rto    = rto[31:0];
  assign ram_wdata.count  = count;

  rtoe_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  rtoe_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (IDX_W'(in_item.entry_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!sample_hit) begin
          state_next = ST_DONE;
        end else if (!measured[addr]) begin
          state_next = ST_FIRST;
        end else begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        alu_op     = ALU_SUB;
        alu_a      = ALU_W'(srtt);
        alu_b      = ALU_W'(rtt);
        state_next = alu_res.borrow ? ST_DIFF_SWAP : ST_VAR3;
      end
      ST_DIFF_SWAP: begin
        alu_op     = ALU_SUB;
        alu_a      = ALU_W'(rtt);
        alu_b      = ALU_W'(srtt);
        state_next = ST_VAR3;
      end
      ST_VAR3: begin
        alu_a      = ALU_W'({rttvar, 1'b0});
        alu_b      = ALU_W'(rttvar);
        state_next = ST_VAR_ADD;
      end
      ST_VAR_ADD: begin
        alu_a      = acc;
        alu_b      = ALU_W'(diff);
        state_next = ST_VAR_FLOOR;
      end
      ST_VAR_FLOOR: begin
        alu_op     = ALU_SUB;
        alu_a      = ALU_W'(nv);
        alu_b      = ALU_W'(min_rttvar);
        state_next = ST_SRTT7;
      end
      ST_SRTT7: begin
        alu_op     = ALU_SUB;
        alu_a      = ALU_W'({srtt, 3'b000});
        alu_b      = ALU_W'(srtt);
        state_next = ST_SRTT_ADD;
      end
      ST_SRTT_ADD: begin
        alu_a      = acc;
        alu_b      = ALU_W'(rtt);
        state_next = ST_RTO;
      end
      ST_RTO: begin
        alu_a      = ALU_W'(ns);
        alu_b      = ALU_W'({nv, 2'b00});
        state_next = ST_CLAMP_LO;
      end
      ST_FIRST: begin
        alu_a      = ALU_W'({rtt, 1'b0});
        alu_b      = ALU_W'(rtt);
        state_next = ST_CLAMP_LO;
      end
      ST_CLAMP_LO: begin
        alu_op     = ALU_SUB;
        alu_a      = rto;
        alu_b      = ALU_W'(rto_min);
        state_next = ST_CLAMP_HI;
      end
      ST_CLAMP_HI: begin
        alu_op     = ALU_SUB;
        alu_a      = ALU_W'(rto_max);
        alu_b      = rto;
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        alu_a      = ALU_W'(count);
        alu_b      = ALU_W'(1'b1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mode     <= in_item.mode;
          addr     <= IDX_W'(in_item.entry_index);
          in_range <= (32'(in_item.entry_index) < 32'(ENTRY_COUNT));
          first    <= 1'b0;
          // A zero or negative delay counts as one tick.
          if (in_item.delay_sample[31] || (in_item.delay_sample == 32'sd0)) begin
            rtt <= 31'd1;
          end else begin
            rtt <= in_item.delay_sample[30:0];
          end
        end
      end
      ST_READ: begin
        if (!in_range) begin
          srtt   <= '0;
          rttvar <= '0;
          rto    <= '0;
          count  <= '0;
        end else if (sample_hit && !measured[addr]) begin
          srtt   <= rtt;
          rttvar <= 32'(rtt[30:1]);
          count  <= entry_rd.count;
          first  <= 1'b1;
        end else begin
          srtt   <= entry_rd.srtt;
          rttvar <= entry_rd.rttvar;
          rto    <= ALU_W'(entry_rd.rto);
          count  <= entry_rd.count;
        end
      end
      ST_DIFF: begin
        if (!alu_res.borrow) begin
          diff <= alu_res.sum[30:0];
        end
      end
      ST_DIFF_SWAP: diff <= alu_res.sum[30:0];
      ST_VAR3:      acc  <= alu_res.sum;
      ST_VAR_ADD:   nv   <= alu_res.sum[33:2];
      ST_VAR_FLOOR: begin
        if (alu_res.borrow) begin
          nv <= 32'(min_rttvar);
        end
      end
      ST_SRTT7:     acc <= alu_res.sum;
      ST_SRTT_ADD:  ns  <= alu_res.sum[33:3];
      ST_RTO: begin
        // Keep the stored timeout when the estimate did not move.
        if ((ns != srtt) || (nv != rttvar)) begin
          rto <= alu_res.sum;
        end
        srtt   <= ns;
        rttvar <= nv;
      end
      ST_FIRST:     rto <= alu_res.sum;
      ST_CLAMP_LO: begin
        if (alu_res.borrow) begin
          rto <= ALU_W'(rto_min);
        end
      end
      ST_CLAMP_HI: begin
        if (alu_res.borrow) begin
          rto <= ALU_W'(rto_max);
        end
      end
      ST_COUNT:     count <= alu_res.sum[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      measured <= '0;
    end else if (ram_we) begin
      written[addr]  <= 1'b1;
      measured[addr] <= 1'b1;
    end else if ((state == ST_READ) && in_range && (mode == MODE_CLEAR)) begin
      measured[addr] <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && advance) begin
      out_item.smoothed_rtt  <= srtt;
      out_item.rtt_variance  <= rttvar;
      out_item.timeout_value <= rto[31:0];
      out_item.sample_count  <= count;
      out_item.was_first     <= first;
    end
  end

endmodule

// ----- design/rtoe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on rtoe_pkg for the address width helper.
module rtoe_ram import rtoe_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [addr_bits(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic [addr_bits(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rtoe_alu.sv -----
// Shared add/subtract unit of the estimator sequencer.
// Depends on rtoe_pkg for the operand width and op/result types.
module rtoe_alu import rtoe_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output alu_res_t         res
);

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   total;
  logic             is_sub;

  assign is_sub = (op == ALU_SUB);
  assign b_eff  = is_sub ? ~b : b;
  assign total  = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, is_sub};

  // Borrow means a < b on a subtract.
  assign res.sum    = total[ALU_W-1:0];
  assign res.borrow = is_sub && !total[ALU_W];

endmodule

// ----- design/rtoe_checker.sv -----
// Port-level checks of the RTO estimator table, bound to the top level.
// Depends on rtoe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtoe_checker import rtoe_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_item,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic        floor_write;
  logic        floor_sel;
  logic        floor_match;
  logic [15:0] floor_wdata_q;

  assign floor_sel   = (paddr[3:2] == REG_MIN_RTTVAR);
  assign floor_write = psel && penable && pwrite && pready && floor_sel;
  assign floor_match = (prdata == {16'b0, floor_wdata_q});

  // Register the low half of pwdata, write or not, for the readback check.
  always_ff @(posedge clk) begin
    floor_wdata_q <= pwdata[15:0];
  end

  // Reset leaves the block ready and with no result pending.
  `CHK_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "reset did not idle the block")

  // An accepted request keeps the block busy on the next cycle.
  `CHK_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "not busy after accept")

  // The variance floor keeps only its low 16 bits.
  `CHK_ASSERT(a_floor_readback, floor_write |=> !floor_sel || floor_match, "floor readback wrong")

  // A stalled result holds.
  `CHK_ASSERT(a_result_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

endmodule

bind rto_estimator_table rtoe_checker u_rtoe_checker (.*);

// ----- bench/tb_rto_estimator_table.sv -----
// Testbench for rto_estimator_table: random and directed sample/clear requests,
// APB register settings, and a scoreboard that predicts every result entry.
// Depends on rtoe_pkg and the rto_estimator_table RTL.
`timescale 1ns / 1ps

module tb_rto_estimator_table;
  import rtoe_pkg::*;

  localparam int ENTRIES = 8;

  // Tracks the estimator table and the clamp registers, and queues the
  // entry each accepted request should report.
  class rto_tracker;
    logic [31:0] rto_lo;
    logic [31:0] rto_hi;
    logic [15:0] var_floor;
    bit          measured [ENTRIES];
    logic [31:0] srtt [ENTRIES];
    logic [31:0] rttvar [ENTRIES];
    logic [31:0] rto [ENTRIES];
    logic [31:0] count [ENTRIES];
    out_item_t   expected_q [$];
    int          errors;
    int          results;
    int          requests;
    int          firsts;
    int          clears;

    function new();
      rto_lo    = 32'd1000;
      rto_hi    = 32'd60000;
      var_floor = 16'd1;
      for (int i = 0; i < ENTRIES; i++) begin
        measured[i] = 1'b0;
        srtt[i]     = '0;
        rttvar[i]   = '0;
        rto[i]      = '0;
        count[i]    = '0;
      end
    endfunction

    function void set_reg(reg_index_t r, logic [31:0] v);
      case (r)
        REG_RTO_MIN:    rto_lo = v;
        REG_RTO_MAX:    rto_hi = v;
        REG_MIN_RTTVAR: var_floor = v[15:0];
        default: ;
      endcase
    endfunction

    // Min clamp first, max second: crossed bounds end at rto_hi.
    function logic [31:0] clamp(logic [63:0] v);
      if (v < {32'd0, rto_lo}) v = {32'd0, rto_lo};
      if (v > {32'd0, rto_hi}) v = {32'd0, rto_hi};
      return v[31:0];
    endfunction

    function void apply_request(in_item_t it);
      logic [63:0] rtt, s, v, d, nv, ns, r;
      logic [2:0]  idx;
      out_item_t   e;
      idx = it.entry_index;
      e = '0;
      requests++;
      if (it.mode == MODE_CLEAR) begin
        measured[idx] = 1'b0;
        clears++;
      end else begin
        rtt = (it.delay_sample[31] || it.delay_sample == 0) ? 64'd1 : {32'd0, it.delay_sample};
        if (!measured[idx]) begin
          e.was_first   = 1'b1;
          firsts++;
          srtt[idx]     = rtt[31:0];
          rttvar[idx]   = (it.delay_sample == 0) ? 32'd0 : rtt[32:1];
          rto[idx]      = clamp(3 * rtt);
          measured[idx] = 1'b1;
        end else begin
          s  = {32'd0, srtt[idx]};
          v  = {32'd0, rttvar[idx]};
          d  = (s >= rtt) ? s - rtt : rtt - s;
          nv = (3 * v + d) >> 2;
          if (nv < {48'd0, var_floor}) nv = {48'd0, var_floor};
          ns = (7 * s + rtt) >> 3;
          // keep the stored timeout when the estimate did not move
          r  = (ns != s || nv != v) ? ns + 4 * nv : {32'd0, rto[idx]};
          srtt[idx]   = ns[31:0];
          rttvar[idx] = nv[31:0];
          rto[idx]    = clamp(r);
        end
        count[idx] = count[idx] + 32'd1;
      end
      e.smoothed_rtt  = srtt[idx][30:0];
      e.rtt_variance  = rttvar[idx];
      e.timeout_value = rto[idx];
      e.sample_count  = count[idx];
      expected_q.push_back(e);
    endfunction

    function void compare(string field, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare("smoothed_rtt", e.smoothed_rtt, got.smoothed_rtt);
      compare("rtt_variance", e.rtt_variance, got.rtt_variance);
      compare("timeout_value", e.timeout_value, got.timeout_value);
      compare("sample_count", e.sample_count, got.sample_count);
      compare("was_first", e.was_first, got.was_first);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rto_tracker tracker = new();
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_seq;
  int settings_used;

  rto_estimator_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run out of time: something hung.
  initial begin
    #(6_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: random stalls, plus a long hold whenever hold_seq advances.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_item);
  end

  function automatic in_item_t sample_req(logic [2:0] idx, logic [31:0] delay);
    in_item_t it;
    it.mode = MODE_SAMPLE;
    it.entry_index = idx;
    it.delay_sample = delay;
    return it;
  endfunction

  function automatic in_item_t clear_req(logic [2:0] idx);
    in_item_t it;
    it = sample_req(idx, $urandom);
    it.mode = MODE_CLEAR;
    return it;
  endfunction

  // Mostly delays near the entry's current estimate, so entries converge and
  // settle; the rest are zero, negative, small, full-range and near-maximum delays.
  function automatic in_item_t random_request();
    in_item_t it;
    longint   d;
    longint   span;
    it.entry_index = 3'($urandom_range(ENTRIES - 1));
    it.mode = ($urandom_range(99) < 8) ? MODE_CLEAR : MODE_SAMPLE;
    case ($urandom_range(11))
      0: it.delay_sample = '0;
      1: it.delay_sample = {1'b1, 31'($urandom)};
      2: it.delay_sample = $urandom;
      3: it.delay_sample = $urandom_range(2000, 1);
      4: it.delay_sample = 32'h7FFF_FFFF - $urandom_range(3);
      5, 6: it.delay_sample = tracker.srtt[it.entry_index];
      default: begin
        span = longint'(tracker.srtt[it.entry_index]) / 4 + 32;
        d = longint'(tracker.srtt[it.entry_index]) + longint'($urandom_range(2 * span)) - span;
        if (d < 1) d = 1;
        if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
        it.delay_sample = 32'(d);
      end
    endcase
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_request(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.apply_request(it);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(r, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int p);
    logic [31:0] lo, hi, fl;
    case (p)
      1: begin lo = 32'd0;          hi = 32'hFFFF_FFFF; fl = 32'h0001_0000; end
      2: begin lo = 32'hFFFF_FFFF;  hi = 32'd0;         fl = 32'hFFFF_FFFF; end
      3: begin lo = 32'd200;        hi = 32'd3000;      fl = 32'd4;         end
      4: begin lo = 32'd5000;       hi = 32'd1000;      fl = 32'd10;        end
      5: begin lo = 32'd1;          hi = 32'h7FFF_FFFF; fl = 32'd0;         end
      6: begin lo = 32'd1000;       hi = 32'd60000;     fl = 32'd1;         end
      default: begin
        lo = $urandom_range(5000);
        hi = $urandom;
        fl = $urandom;
      end
    endcase
    write_reg(REG_RTO_MIN, lo);
    write_reg(REG_RTO_MAX, hi);
    write_reg(REG_MIN_RTTVAR, fl);
    settings_used++;
  endtask

  task automatic run_directed();
    send_request(sample_req(3'd0, 32'd0));           // first sample, zero delay
    send_request(sample_req(3'd1, -32'sd5));         // first sample, negative delay
    send_request(sample_req(3'd2, 32'h8000_0000));   // most negative delay
    send_request(sample_req(3'd3, 32'h7FFF_FFFF));   // 3*rtt past 32 bits
    send_request(sample_req(3'd7, 32'd2));
    send_request(sample_req(3'd7, 32'd2));           // estimate unchanged
    send_request(sample_req(3'd3, 32'd1));           // large difference
    send_request(sample_req(3'd3, 32'h7FFF_FFFF));
    send_request(sample_req(3'd0, 32'hFFFF_FFFF));
    send_request(clear_req(3'd7));
    send_request(sample_req(3'd7, 32'd500));         // first again after clear
    send_request(clear_req(3'd5));                   // clear of unmeasured entry
    send_request(sample_req(3'd4, 32'd1));
    send_request(sample_req(3'd4, 32'd1));           // variance held at floor
    send_request(sample_req(3'd6, 32'd2));
    send_request(sample_req(3'd6, 32'd2));
    send_request(sample_req(3'd0, 32'd40000));
    send_request(sample_req(3'd1, 32'h7FFF_FFFE));
  endtask

  initial begin
    int p;
    int n;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_seq      = 0;
    settings_used = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (p = 0; p < 8; p++) begin
      wait_drain();
      if (p > 0) apply_setting(p);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      // re-clamp a settled entry under the new bounds
      send_request(sample_req(3'd6, tracker.srtt[6]));
      for (n = 0; n < 50; n++) begin
        if (n == 25 && (p == 0 || p == 5)) hold_seq++;
        if (n == 25 && p == 3) wait_drain();
        send_request(random_request());
      end
    end

    wait_drain();
    $display("Checked %0d results for %0d requests (%0d first samples, %0d clears).",
             tracker.results, tracker.requests, tracker.firsts, tracker.clears);
    $display("Covered %0d register settings, crossed and open clamp bounds, all idle patterns.",
             settings_used);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
